// File: rtl/assert_macros.svh
// Assertion macros used by the stereo RMS meter checker.
// Needs a clk_i and an active-low rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define SRMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also holds through reset
`define SRMS_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// File: rtl/srms_pkg.sv
// Shared types, constants and width helpers for the stereo block RMS meter.
// No dependencies; imported by every module of the block.
package srms_pkg;

  localparam int IN_W            = 16;   // sample port width
  localparam int LEVEL_W         = 16;   // reported level width
  localparam int BLK_W           = 13;   // reported sample count width
  localparam int SUM_W_CAP       = 64;   // sum widths are capped at 64 bits
  localparam int MAX_BLOCK_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_END  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_CALC,
    ST_OUT
  } state_e;

  // control from the sequencer to each channel lane
  typedef struct packed {
    logic push;
    logic start;
  } lane_ctrl_t;

  // status from a lane back to the sequencer
  typedef struct packed {
    logic done;
  } lane_stat_t;

  // width of a sum of squares, capped at the saturation width
  function automatic int sum_width(int max_block, int sample_bits);
    int raw;
    raw = 2 * sample_bits - 1 + $clog2(max_block + 1);
    return (raw > SUM_W_CAP) ? SUM_W_CAP : raw;
  endfunction

  // width of a counter that can hold max_block itself
  function automatic int cnt_width(int max_block);
    return $clog2(max_block + 1);
  endfunction

endpackage

// File: rtl/srms_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on srms_pkg only for the shared import convention.
module srms_div import srms_pkg::*; #(
  parameter int DIVIDEND_W = 43,
  parameter int DIVISOR_W  = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic                  done_o
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [STEP_W-1:0]     step_q;
  logic [DIVISOR_W:0]    rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  dvsr_q;

  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_nx;
  logic                  fits;

  // one trial subtraction; remainder stays below the divisor
  assign rem_sh = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvsr_q});
  assign rem_nx = fits ? (rem_sh - {1'b0, dvsr_q}) : rem_sh;

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(DIVIDEND_W);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath: dividend bits shift out, quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_nx;
      quo_q  <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// File: rtl/srms_sqrt.sv
// Digit-by-digit integer floor square root, one root bit per cycle.
// Depends on srms_pkg only for the shared import convention.
module srms_sqrt import srms_pkg::*; #(
  parameter int ROOT_W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2*ROOT_W-1:0]   radicand_i,
  output logic [ROOT_W-1:0]     root_o,
  output logic                  done_o
);

  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [REM_W-1:0]  rem_q;
  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W-1:0] root_q;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // bring down two radicand bits, try 4*root + 1
  assign rem_sh = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(ROOT_W);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      rad_q  <= radicand_i;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? (rem_sh - trial) : rem_sh;
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// File: rtl/srms_lane.sv
// One channel lane: squarer, saturating accumulator, divider and root unit.
// Depends on srms_pkg, srms_div and srms_sqrt.
module srms_lane import srms_pkg::*; #(
  parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lane_ctrl_t                       ctrl_i,
  input  logic [IN_W-1:0]                  sample_i,
  input  logic [cnt_width(MAX_BLOCK)-1:0]  count_i,
  output lane_stat_t                       stat_o,
  output logic [LEVEL_W-1:0]               level_o
);

  localparam int SB    = SAMPLE_BITS;
  localparam int SQ_W  = 2 * SB;
  localparam int SUM_W = sum_width(MAX_BLOCK, SAMPLE_BITS);
  localparam int CNT_W = cnt_width(MAX_BLOCK);

  logic [SB+IN_W-1:0]    sample_ext;
  logic [SB-1:0]         sample_v;
  logic [SB-1:0]         mag;
  logic [SQ_W-1:0]       square;
  logic [SQ_W-1:0]       sq_q;
  logic                  sq_vld_q;
  logic [SUM_W-1:0]      sum_q;
  logic [SUM_W-1:0]      sum_d;
  logic [SUM_W:0]        sum_add;
  logic [SUM_W-1:0]      quotient;
  logic                  div_done;
  logic [SB-1:0]         root;
  logic                  sqrt_done;
  logic [SB+LEVEL_W-1:0] root_ext;
  logic [LEVEL_W-1:0]    level_q;

  // take the low SAMPLE_BITS of the port as two's complement
  assign sample_ext = {{SB{1'b0}}, sample_i};
  assign sample_v   = sample_ext[SB-1:0];
  assign mag        = sample_v[SB-1] ? (~sample_v + SB'(1)) : sample_v;
  assign square     = SQ_W'(mag) * SQ_W'(mag);

  // square stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else begin
      sq_vld_q <= ctrl_i.push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      sq_q <= square;
    end
  end

  // accumulate, holding at all ones on carry out
  assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(sq_q);

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.start) begin
      sum_d = '0;
    end else if (sq_vld_q) begin
      sum_d = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // mean of squares, then floor root
  srms_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.start),
    .dividend_i (sum_q),
    .divisor_i  (count_i),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  srms_sqrt #(
    .ROOT_W     (SB)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_done),
    .radicand_i (quotient[SQ_W-1:0]),
    .root_o     (root),
    .done_o     (sqrt_done)
  );

  // last reported level
  assign root_ext = {{LEVEL_W{1'b0}}, root};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (sqrt_done) begin
      level_q <= root_ext[LEVEL_W-1:0];
    end
  end

  assign stat_o.done = sqrt_done;
  assign level_o     = level_q;

endmodule

// File: rtl/stereo_block_rms_meter_core.sv
// Top level of the stereo block RMS meter: sequencer, two lanes, result merge.
// Depends on srms_pkg and srms_lane.
//
// Push requests are taken one per clock while the sequencer is idle: each
// sample is squared in its lane and added to that channel's sum in the
// following cycle. A block-end request stalls the input while both lanes run
// their one-bit-per-cycle divider and then their root unit side by side; an
// empty block skips both. A block end also waits while the previous result
// still sits unread in the output register. The finished result sits in that
// output register, so pushes of the next block are taken while it waits to be
// read. Pushes beyond MAX_BLOCK in one block are dropped and reported in the
// overflowed flag. No clearing pass runs after reset.
module stereo_block_rms_meter_core import srms_pkg::*; #(
  parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [IN_W-1:0]    left_sample_i,
  input  logic [IN_W-1:0]    right_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [LEVEL_W-1:0] rms_left_o,
  output logic [LEVEL_W-1:0] rms_right_o,
  output logic [BLK_W-1:0]   block_samples_o,
  output logic               overflowed_o
);

  localparam int CNT_W = cnt_width(MAX_BLOCK);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q;
  logic               drop_q;
  logic [CNT_W-1:0]   blk_cnt_q;
  logic               blk_drop_q;
  logic               done_l_q, done_r_q;
  logic               out_valid_q;
  logic [LEVEL_W-1:0] rms_left_q, rms_right_q;
  logic [BLK_W-1:0]   block_samples_q;
  logic               overflowed_q;

  logic               in_accept;
  logic               is_end;
  logic               full;
  logic               out_free;
  logic               load_out;
  lane_ctrl_t         lane_ctrl;
  lane_stat_t         stat_l, stat_r;
  logic [LEVEL_W-1:0] level_l, level_r;
  logic [CNT_W+BLK_W-1:0] blk_cnt_ext;

  assign in_accept = in_valid_i && !in_stall_o;
  assign is_end    = (op_i == OP_END);
  assign full      = (count_q == CNT_W'(MAX_BLOCK));
  assign out_free  = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && is_end) begin
          state_d = (count_q != '0) ? ST_START : ST_OUT;
        end
      end
      ST_START: state_d = ST_CALC;
      ST_CALC: begin
        if (done_l_q && done_r_q) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // input is held off whenever the sequencer is busy
  assign in_stall_o = (state_q != ST_IDLE);

  // state outputs
  always_comb begin
    lane_ctrl.push  = in_accept && !is_end && !full;
    lane_ctrl.start = (state_q == ST_START);
    load_out        = (state_q == ST_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sample count and drop flag of the open block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      drop_q     <= 1'b0;
      blk_cnt_q  <= '0;
      blk_drop_q <= 1'b0;
    end else if (in_accept && is_end) begin
      blk_cnt_q  <= count_q;
      blk_drop_q <= drop_q;
      count_q    <= '0;
      drop_q     <= 1'b0;
    end else if (in_accept) begin
      if (full) begin
        drop_q  <= 1'b1;
      end else begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  // lanes report done once each; collect both
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_l_q <= 1'b0;
      done_r_q <= 1'b0;
    end else if (lane_ctrl.start) begin
      done_l_q <= 1'b0;
      done_r_q <= 1'b0;
    end else begin
      done_l_q <= done_l_q || stat_l.done;
      done_r_q <= done_r_q || stat_r.done;
    end
  end

  srms_lane #(
    .MAX_BLOCK   (MAX_BLOCK),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_l (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .sample_i (left_sample_i),
    .count_i  (blk_cnt_q),
    .stat_o   (stat_l),
    .level_o  (level_l)
  );

  srms_lane #(
    .MAX_BLOCK   (MAX_BLOCK),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .sample_i (right_sample_i),
    .count_i  (blk_cnt_q),
    .stat_o   (stat_r),
    .level_o  (level_r)
  );

  // merge both lanes into the result register
  assign blk_cnt_ext = {{BLK_W{1'b0}}, blk_cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      rms_left_q      <= level_l;
      rms_right_q     <= level_r;
      block_samples_q <= blk_cnt_ext[BLK_W-1:0];
      overflowed_q    <= blk_drop_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign rms_left_o      = rms_left_q;
  assign rms_right_o     = rms_right_q;
  assign block_samples_o = block_samples_q;
  assign overflowed_o    = overflowed_q;

endmodule

// File: rtl/srms_checker.sv
// Port-level checks for the stereo block RMS meter, bound to the top level.
// Depends on srms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srms_checker import srms_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               op_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [LEVEL_W-1:0] rms_left_o,
  input logic [LEVEL_W-1:0] rms_right_o,
  input logic [BLK_W-1:0]   block_samples_o,
  input logic               overflowed_o
);

  localparam int EXT_W = BLK_W + 32;
  localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_BLOCK);
  localparam logic [BLK_W-1:0] MAX_SEEN = MAX_EXT[BLK_W-1:0];

  logic                           end_accept;
  logic                           out_held;
  logic                           drop_seen;
  logic [2*LEVEL_W+BLK_W:0]       out_payload;

  assign end_accept  = in_valid_i && !in_stall_o && (op_i == OP_END);
  assign out_held    = out_valid_o && out_stall_i;
  assign drop_seen   = out_valid_o && overflowed_o;
  assign out_payload = {rms_left_o, rms_right_o, block_samples_o, overflowed_o};

  // a held result keeps its payload
  `SRMS_ASSERT(a_out_hold, out_held |=> out_valid_o && $stable(out_payload), "held result changed")

  // an accepted block end is always followed by a stalled input
  `SRMS_ASSERT(a_end_busy, end_accept |=> in_stall_o, "block end did not stall input")

  // a result appears only out of a block-end computation
  `SRMS_ASSERT(a_out_source, $rose(out_valid_o) |-> $past(in_stall_o), "result without block end")

  // dropped pushes only happen with a full block
  `SRMS_ASSERT(a_drop_full, drop_seen |-> block_samples_o == MAX_SEEN, "drop flag on a short block")

  // no result while reset is applied
  `SRMS_ASSERT_ANY(a_rst_quiet, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind stereo_block_rms_meter_core srms_checker #(
  .MAX_BLOCK (MAX_BLOCK)
) u_srms_checker (.*);

// File: sim/testbench.sv
// Testbench for stereo_block_rms_meter_core: random and directed push and
// block-end requests, with a scoreboard class that predicts every level report.
// Depends on srms_pkg and the RTL of the block only.
module testbench;
  import srms_pkg::*;

  localparam int MAX_BLOCK    = MAX_BLOCK_DEF;
  localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
  localparam int RANDOM_ITEMS = 950;
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int IDLE_LIMIT   = 5000;   // watchdog: cycles with no request moving
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 150;

  // one level report of a finished block
  typedef struct {
    logic [LEVEL_W-1:0] rms_l;
    logic [LEVEL_W-1:0] rms_r;
    logic [BLK_W-1:0]   count;
    logic               ovf;
  } level_report_t;

  // predicts level reports from accepted requests and checks the outputs
  class level_scoreboard;
    level_report_t      expected_q[$];
    bit [63:0]          sum_l;
    bit [63:0]          sum_r;
    int unsigned        count;
    bit                 dropped;
    bit [LEVEL_W-1:0]   lvl_l;
    bit [LEVEL_W-1:0]   lvl_r;
    int                 errors;
    int                 checked;

    function new();
      sum_l   = '0;
      sum_r   = '0;
      count   = 0;
      dropped = 1'b0;
      lvl_l   = '0;
      lvl_r   = '0;
      errors  = 0;
      checked = 0;
    endfunction

    // square of the low SAMPLE_BITS bits taken as two's complement
    function bit [63:0] square_of(logic [IN_W-1:0] raw);
      logic signed [SAMPLE_BITS-1:0] v;
      longint s;
      v = raw[SAMPLE_BITS-1:0];
      s = v;
      if (s < 0) s = -s;
      return 64'(s) * 64'(s);
    endfunction

    // sums hold at the 64-bit ceiling
    function bit [63:0] add_capped(bit [63:0] a, bit [63:0] b);
      bit [63:0] s;
      s = a + b;
      return (s < a) ? '1 : s;
    endfunction

    // integer floor square root, one result bit per step from the top
    function bit [63:0] floor_root(bit [63:0] n);
      bit [63:0] root;
      bit [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= n) root = trial;
      end
      return root;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // update the block state for one accepted request
    function void note_request(logic op, logic [IN_W-1:0] left, logic [IN_W-1:0] right);
      level_report_t rpt;
      if (op == OP_PUSH) begin
        if (count >= MAX_BLOCK) begin
          dropped = 1'b1;
        end else begin
          sum_l = add_capped(sum_l, square_of(left));
          sum_r = add_capped(sum_r, square_of(right));
          count++;
        end
      end else begin
        // empty block keeps the previous levels
        if (count > 0) begin
          lvl_l = LEVEL_W'(floor_root(sum_l / 64'(count)));
          lvl_r = LEVEL_W'(floor_root(sum_r / 64'(count)));
        end
        rpt.rms_l = lvl_l;
        rpt.rms_r = lvl_r;
        rpt.count = count[BLK_W-1:0];
        rpt.ovf   = dropped;
        expected_q.push_back(rpt);
        sum_l   = '0;
        sum_r   = '0;
        count   = 0;
        dropped = 1'b0;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // compare one accepted result with the oldest expected report
    task check_result(logic [LEVEL_W-1:0] rms_l, logic [LEVEL_W-1:0] rms_r,
                      logic [BLK_W-1:0] blk_cnt, logic ovf);
      level_report_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("level report with none expected (%0d %0d %0d %0d)",
                         rms_l, rms_r, blk_cnt, ovf));
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (rms_l !== want.rms_l)
          report($sformatf("report %0d rms_left %0d, expected %0d", checked, rms_l, want.rms_l));
        if (rms_r !== want.rms_r)
          report($sformatf("report %0d rms_right %0d, expected %0d", checked, rms_r,
                           want.rms_r));
        if (blk_cnt !== want.count)
          report($sformatf("report %0d block_samples %0d, expected %0d", checked, blk_cnt,
                           want.count));
        if (ovf !== want.ovf)
          report($sformatf("report %0d overflowed %0d, expected %0d", checked, ovf, want.ovf));
      end
    endtask

    task check_leftovers();
      if (expected_q.size() != 0)
        report($sformatf("%0d level reports never arrived", expected_q.size()));
    endtask
  endclass

  logic               clk_i          = 1'b0;
  logic               rst_ni;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic               op_i           = OP_PUSH;
  logic [IN_W-1:0]    left_sample_i  = '0;
  logic [IN_W-1:0]    right_sample_i = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [LEVEL_W-1:0] rms_left_o;
  logic [LEVEL_W-1:0] rms_right_o;
  logic [BLK_W-1:0]   block_samples_o;
  logic               overflowed_o;

  level_scoreboard sb = new();
  bit              calm       = 1'b0;  // no idling on either side while set
  bit              hold_armed = 1'b0;  // receiver does one long hold-off when set
  int              n_push     = 0;
  int              n_end      = 0;

  stereo_block_rms_meter_core #(
    .MAX_BLOCK  (MAX_BLOCK),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .rms_left_o     (rms_left_o),
    .rms_right_o    (rms_right_o),
    .block_samples_o(block_samples_o),
    .overflowed_o   (overflowed_o)
  );

  always #1 clk_i = ~clk_i;

  // mostly short gaps, a few long ones
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // sample values weighted toward the extremes and small magnitudes
  function logic [IN_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 6)) - 16'd3;
      default: return 16'($urandom());
    endcase
  endfunction

  // offer one request and hold it until accepted
  task send_request(op_e op, logic [IN_W-1:0] left, logic [IN_W-1:0] right);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    left_sample_i  <= left;
    right_sample_i <= right;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op == OP_PUSH) n_push++;
    else n_end++;
  endtask

  // monitor both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_request(op_i, left_sample_i, right_sample_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(rms_left_o, rms_right_o, block_samples_o, overflowed_o);
    end
  end

  // receiver: random stall runs, plus one long hold-off when armed
  initial begin : receiver
    int  run;
    int  r;
    bit  level;
    run   = 0;
    level = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_armed && out_valid_o) begin
        hold_armed = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        run = 0;
      end
      if (run == 0) begin
        level = ($urandom_range(0, 99) < 35);
        r = $urandom_range(0, 99);
        if (r < 75) run = $urandom_range(1, 3);
        else if (r < 95) run = $urandom_range(4, 10);
        else run = $urandom_range(20, 60);
      end
      out_stall_i <= calm ? 1'b0 : level;
      run--;
    end
  end

  // watchdog: ends the run when no request moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("watchdog: no request moved for %0d cycles", idle);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : stimulus
    int blk_len;
    int r;
    int random_sent;
    int cycles;
    random_sent = 0;
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty block right after reset reports zero levels
    send_request(OP_END, 16'hFFFF, 16'hFFFF);
    // extremes of both channels in one block
    send_request(OP_PUSH, 16'h8000, 16'h7FFF);
    send_request(OP_PUSH, 16'h0000, 16'h0000);
    send_request(OP_PUSH, 16'h0001, 16'hFFFF);
    send_request(OP_PUSH, 16'h7FFF, 16'h8000);
    send_request(OP_END, 16'h0000, 16'h0000);
    // empty block repeats the previous levels
    send_request(OP_END, 16'h5555, 16'hAAAA);
    // largest level
    send_request(OP_PUSH, 16'h8000, 16'h8000);
    send_request(OP_END, 16'h0000, 16'h0000);
    send_request(OP_PUSH, 16'h0000, 16'h0000);
    send_request(OP_END, 16'h0000, 16'h0000);
    send_request(OP_PUSH, 16'hFFFF, 16'h0001);
    send_request(OP_PUSH, 16'h7FFF, 16'h8000);
    send_request(OP_END, 16'h0000, 16'h0000);

    // random blocks; the receiver holds off once early on
    hold_armed = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) blk_len = 0;
      else if (r < 90) blk_len = $urandom_range(1, 24);
      else blk_len = $urandom_range(25, 100);
      for (int k = 0; k < blk_len; k++)
        send_request(OP_PUSH, pick_sample(), pick_sample());
      send_request(OP_END, 16'($urandom()), 16'($urandom()));
      random_sent += blk_len + 1;
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    // wait for the remaining reports, then a quiet tail
    cycles = 0;
    while (sb.pending() > 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    sb.check_leftovers();

    $display("Covered %0d pushes and %0d block ends, %0d level reports checked,",
             n_push, n_end, sb.checked);
    $display("including empty blocks, extreme samples and a long output hold-off.");
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/srms_pkg.sv
rtl/srms_div.sv
rtl/srms_sqrt.sv
rtl/srms_lane.sv
rtl/stereo_block_rms_meter_core.sv
rtl/srms_checker.sv
sim/testbench.sv
